// ===== hw/rtl/pjq_pkg.sv =====
// ----------------------------------------------------------------------------
// pjq_pkg: shared types and constants of the priority job queue
// Field widths, queue sizing, status and mode codes, and the structs that
// travel between the top level and the queue sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pjq_pkg;

  // Queue sizing
  localparam int QUEUE_DEPTH = 8;
  localparam int JOB_COUNT   = 3;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Port field widths
  localparam int MODE_W   = 2;
  localparam int JOB_ID_W = 8;
  localparam int STATUS_W = 2;
  localparam int JOB_W    = 2;
  localparam int QCOUNT_W = 4;
  localparam int PRIO_W   = 8;
  localparam int MASK_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_JOB0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_JOB1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_JOB2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_MASK  = 2'd3;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_SUBMIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_OK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY   = 2'd2;

  // One queue entry
  typedef struct packed {
    logic [JOB_W-1:0]  job;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [JOB_COUNT-1:0][PRIO_W-1:0] prio;
    logic [MASK_W-1:0]                sig_mask;
  } cfg_t;

  // Incoming request word
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [JOB_ID_W-1:0] job_id;
    logic                pointer_given;
    logic                engine_busy;
  } req_t;

  // Outgoing result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                dispatch_valid;
    logic [JOB_W-1:0]    dispatch_job;
    logic [QCOUNT_W-1:0] queue_count;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pjq_core.sv =====
// ----------------------------------------------------------------------------
// pjq_core: queue storage and admission sequencer
// Holds the sorted job queue in a one-read, one-write memory and walks it
// one entry at a time for duplicate search, ordered insert and pop.
// ----------------------------------------------------------------------------
`default_nettype none

module pjq_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pjq_pkg::cfg_t cfg_i,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire pjq_pkg::req_t req_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output pjq_pkg::res_t      res_o
);
  import pjq_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_EV  = 4'd2;
  localparam logic [3:0] S_SHIFT_RD = 4'd3;
  localparam logic [3:0] S_SHIFT_WR = 4'd4;
  localparam logic [3:0] S_INSERT   = 4'd5;
  localparam logic [3:0] S_FRONT    = 4'd6;
  localparam logic [3:0] S_POP_RD   = 4'd7;
  localparam logic [3:0] S_POP_WR   = 4'd8;
  localparam logic [3:0] S_RESP     = 4'd9;

  logic [3:0]          state_q, state_d;
  logic                init_q, init_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic                found_q, found_d;
  logic                dup_q, dup_d;
  logic                busy_q, busy_d;
  logic [JOB_W-1:0]    job_q, job_d;
  logic [PRIO_W-1:0]   prio_q, prio_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                dv_q, dv_d;
  logic [JOB_W-1:0]    dj_q, dj_d;

  // Queue memory: one read port with registered data, one write port
  entry_t              mem_q [QUEUE_DEPTH];
  entry_t              rd_data_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Helpers
  logic             accept;
  logic [JOB_W-1:0] id_sel;
  logic [CNT_W-1:0] idx_next_cnt;
  logic             last;
  logic             hit;
  logic             higher;

  assign accept       = req_valid_i && req_ready_o;
  assign id_sel       = req_i.job_id[JOB_W-1:0];
  assign idx_next_cnt = CNT_W'(idx_q) + CNT_W'(1);
  assign last         = (idx_next_cnt == count_q);
  assign hit          = (rd_data_q.job == job_q);
  assign higher       = (prio_q > rd_data_q.prio);

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = '{status: status_q, dispatch_valid: dv_q, dispatch_job: dj_q,
                         queue_count: QCOUNT_W'(count_q)};

  // Sequencer
  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    count_d  = count_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    found_d  = found_q;
    dup_d    = dup_q;
    busy_d   = busy_q;
    job_d    = job_q;
    prio_d   = prio_q;
    status_d = status_q;
    dv_d     = dv_q;
    dj_d     = dj_q;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = '{job: job_q, prio: prio_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          dv_d     = 1'b0;
          dj_d     = '0;
          busy_d   = req_i.engine_busy;
          job_d    = id_sel;
          prio_d   = cfg_i.prio[id_sel];
          state_d  = S_RESP;
          case (req_i.mode)
            MODE_INIT: begin
              if (req_i.pointer_given) begin
                init_d   = 1'b0;
                status_d = ST_NOT_OK;
              end else begin
                init_d  = 1'b1;
                count_d = '0;
              end
            end
            MODE_TICK: begin
              // entry 0 is being read this cycle
              if (count_q != '0) begin
                dv_d    = 1'b1;
                state_d = S_FRONT;
              end
            end
            MODE_SUBMIT: begin
              if (!init_q || !req_i.pointer_given ||
                  req_i.job_id >= JOB_ID_W'(JOB_COUNT)) begin
                status_d = ST_NOT_OK;
              end else if (!cfg_i.sig_mask[id_sel]) begin
                status_d = ST_NOT_OK;
              end else if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
                status_d = ST_BUSY;
              end else if (count_q == '0) begin
                // empty queue: dispatched straight to the engine, and also queued if the engine is busy
                dv_d = 1'b1;
                dj_d = id_sel;
                if (req_i.engine_busy) begin
                  pos_d   = '0;
                  state_d = S_INSERT;
                end
              end else begin
                idx_d   = '0;
                pos_d   = IDX_W'(count_q);
                found_d = 1'b0;
                dup_d   = 1'b0;
                state_d = S_SCAN_RD;
              end
            end
            default: begin
              status_d = ST_NOT_OK;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        rd_addr = idx_q;
        state_d = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        // duplicate search and first lower priority in one pass
        dup_d   = dup_q | hit;
        found_d = found_q | higher;
        if (!found_q && higher) begin
          pos_d = idx_q;
        end
        if (!last) begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_SCAN_RD;
        end else if (dup_q || hit) begin
          status_d = ST_NOT_OK;
          state_d  = S_RESP;
        end else if (!(found_q || higher)) begin
          state_d = S_INSERT;
        end else begin
          idx_d   = IDX_W'(count_q - CNT_W'(1));
          state_d = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        rd_addr = idx_q;
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        // move one entry back to open the insert slot
        wr_en   = 1'b1;
        wr_addr = idx_q + IDX_W'(1);
        wr_data = rd_data_q;
        if (idx_q == pos_q) begin
          state_d = S_INSERT;
        end else begin
          idx_d   = idx_q - IDX_W'(1);
          state_d = S_SHIFT_RD;
        end
      end
      S_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        count_d = count_q + CNT_W'(1);
        state_d = S_RESP;
      end
      S_FRONT: begin
        dj_d = rd_data_q.job;
        if (busy_q) begin
          state_d = S_RESP;
        end else if (count_q == CNT_W'(1)) begin
          count_d = '0;
          state_d = S_RESP;
        end else begin
          idx_d   = IDX_W'(1);
          state_d = S_POP_RD;
        end
      end
      S_POP_RD: begin
        rd_addr = idx_q;
        state_d = S_POP_WR;
      end
      S_POP_WR: begin
        // move one entry forward over the popped front
        wr_en   = 1'b1;
        wr_addr = idx_q - IDX_W'(1);
        wr_data = rd_data_q;
        if (last) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_POP_RD;
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      init_q  <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      count_q <= count_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    found_q  <= found_d;
    dup_q    <= dup_d;
    busy_q   <= busy_d;
    job_q    <= job_d;
    prio_q   <= prio_d;
    status_q <= status_d;
    dv_q     <= dv_d;
    dj_q     <= dj_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/priority_job_queue.sv =====
// ----------------------------------------------------------------------------
// priority_job_queue: admission queue for crypto jobs
// Configuration registers, input handshake and the registered result word
// around the queue sequencer.
// ----------------------------------------------------------------------------
// One word in gives one result word out, in order. Init, submits refused before
// the queue scan and ticks on an empty queue go straight to the result; a direct
// dispatch that the engine refuses is also written into the queue; a tick reads
// the front entry and, unless the engine is busy, moves each later one forward;
// a queued submit scans every entry, moves back those from the insert slot on
// and writes the new entry, and a submit found already queued scans every entry
// and is refused. Every step is paced by the single read port of the queue
// memory, so the whole block works on one word at a time and is not ready until
// that word's result has been handed to the output register. The output register
// lets the next word be taken while a result waits there.
`default_nettype none

module priority_job_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [pjq_pkg::MODE_W-1:0]        mode_i,
  input  wire logic [pjq_pkg::JOB_ID_W-1:0]      job_id_i,
  input  wire logic                              pointer_given_i,
  input  wire logic                              engine_busy_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [pjq_pkg::STATUS_W-1:0]           status_o,
  output logic                                   dispatch_valid_o,
  output logic [pjq_pkg::JOB_W-1:0]              dispatch_job_o,
  output logic [pjq_pkg::QCOUNT_W-1:0]           queue_count_o,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pjq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pjq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pjq_pkg::*;

  // Configuration registers
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prio     <= '0;
      cfg_q.sig_mask <= MASK_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PRIO_JOB0: cfg_q.prio[0]  <= cfg_data_i;
        CFG_PRIO_JOB1: cfg_q.prio[1]  <= cfg_data_i;
        CFG_PRIO_JOB2: cfg_q.prio[2]  <= cfg_data_i;
        CFG_SIG_MASK:  cfg_q.sig_mask <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  req_t req;
  res_t res;
  logic res_valid;
  logic res_ready;

  assign req = '{mode: mode_i, job_id: job_id_i, pointer_given: pointer_given_i,
                 engine_busy: engine_busy_i};

  pjq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register
  logic out_valid_q;
  res_t out_q;

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign dispatch_valid_o = out_q.dispatch_valid;
  assign dispatch_job_o   = out_q.dispatch_job;
  assign queue_count_o    = out_q.queue_count;

endmodule

`default_nettype wire

// ===== hw/rtl/pjq_checker.sv =====
// ----------------------------------------------------------------------------
// pjq_checker: port-level checks of the priority job queue
// Watches the top level's ports and flags result words that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module pjq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [pjq_pkg::STATUS_W-1:0]      status_o,
  input wire logic                              dispatch_valid_o,
  input wire logic [pjq_pkg::JOB_W-1:0]         dispatch_job_o,
  input wire logic [pjq_pkg::QCOUNT_W-1:0]      queue_count_o
);
  import pjq_pkg::*;

  // Taking a word starts work, so ready drops next cycle
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a word was taken");

  // A result without a dispatch names no job
  a_no_stray_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dispatch_valid_o |-> dispatch_job_o == '0)
    else $error("job id shown without a dispatch");

  // A dispatch only goes with an ok status
  a_dispatch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dispatch_valid_o |-> status_o == ST_OK)
    else $error("dispatch with a failing status");

  // Fill level and status code stay in range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (queue_count_o <= QCOUNT_W'(QUEUE_DEPTH)) &&
                    (status_o == ST_OK || status_o == ST_NOT_OK || status_o == ST_BUSY))
    else $error("queue count or status out of range");

  // A waiting result holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
                                   $stable(queue_count_o))
    else $error("result changed while stalled");

endmodule

bind priority_job_queue pjq_checker u_pjq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .dispatch_valid_o (dispatch_valid_o),
  .dispatch_job_o   (dispatch_job_o),
  .queue_count_o    (queue_count_o)
);

`default_nettype wire
